>>> hw/rtl/ocl_pkg.sv
// ----------------------------------------------------------------------------
// ocl_pkg
// Types and codes shared by the ordered character list and its storage cells.
// ----------------------------------------------------------------------------
package ocl_pkg;

    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_FIND      = 2'd1,
        OP_DEL_FIRST = 2'd2,
        OP_DEL_ALL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam int unsigned LengthWidth = 5;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic                     found;
        logic [LengthWidth-1:0]   length;
    } result_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic push;    // shift towards the back, cell 0 takes the new value
        logic rotate;  // shift towards the front, head re-enters at the tail
        logic keep;    // head entry survives this rotation step
    } cell_ctrl_t;

endpackage

>>> hw/rtl/ocl_cell.sv
// ----------------------------------------------------------------------------
// ocl_cell
// One storage cell of the list chain: holds a byte and trades it with its
// neighbours on push and rotate steps.
// ----------------------------------------------------------------------------
module ocl_cell (
    input  logic              clk,
    input  ocl_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]        prev_data,
    input  logic [7:0]        next_data,
    input  logic [7:0]        head_data,
    input  logic              tail_sel,
    output logic [7:0]        data
);
    import ocl_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.push)
        begin
            data_next = prev_data;
        end
        else if (ctrl.rotate)
        begin
            // the kept head lands at the current tail, everything else moves up
            if (tail_sel && ctrl.keep)
            begin
                data_next = head_data;
            end
            else
            begin
                data_next = next_data;
            end
        end
        else
        begin
            // hold the entry
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hw/rtl/ordered_char_list.sv
// ----------------------------------------------------------------------------
// ordered_char_list
// Bounded list of bytes, newest first: push, find, delete first, delete all.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. It rotates the
// list once through the chain of cells, one entry per cycle, checking the
// head entry against the value; delete first drops the first match, delete
// all every match, and a push then shifts the new value in at the front if
// the list is not full. Busy stays high through the scan and the finishing
// step; done is high for a single cycle, as busy falls, and the result
// appears on result with it; a new operation may be started in that same
// cycle. The receiver cannot stall the result, so it must take it in that
// cycle. The entry count is cleared by reset; the cells need no clearing.
module ordered_char_list #(
    parameter int unsigned LIST_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ocl_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output ocl_pkg::result_t result
);
    import ocl_pkg::*;

    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned IW = $clog2(LIST_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   remain_reg, remain_next;
    op_t             op_reg, op_next;
    logic [7:0]      value_reg, value_next;
    logic            had_reg, had_next;
    logic            dropped_reg, dropped_next;
    logic            empty_reg, empty_next;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;

    cell_ctrl_t      ctrl;
    logic [7:0]      cell_data [LIST_DEPTH];
    logic [IW-1:0]   tail_idx;
    logic            accept;
    logic            match;
    logic            drop;
    logic [CW-1:0]   tail_len;

    assign accept   = start && (state_reg == S_IDLE);
    assign match    = (cell_data[0] == value_reg);
    assign drop     = match && ((op_reg == OP_DEL_ALL) ||
                                ((op_reg == OP_DEL_FIRST) && !dropped_reg));
    assign tail_len = count_reg - CW'(1);
    assign tail_idx = tail_len[IW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        had_next     = had_reg;
        dropped_next = dropped_reg;
        empty_next   = empty_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ctrl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = cmd.op;
                    value_next   = cmd.value;
                    had_next     = 1'b0;
                    dropped_next = 1'b0;
                    remain_next  = count_reg;
                    empty_next   = (count_reg == '0);
                    state_next   = (count_reg == '0) ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // rotate the head round to the tail, or drop it on a delete
                ctrl.rotate = 1'b1;
                ctrl.keep   = !drop;
                had_next    = had_reg || match;
                if (drop)
                begin
                    count_next   = count_reg - CW'(1);
                    dropped_next = 1'b1;
                end
                remain_next = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                result_next.found = had_reg;
                if (op_reg == OP_PUSH)
                begin
                    if (count_reg == CW'(LIST_DEPTH))
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push          = 1'b1;
                        count_next         = count_reg + CW'(1);
                        result_next.status = ST_OK;
                    end
                end
                else if (empty_reg)
                begin
                    result_next.status = ST_EMPTY;
                end
                else if (!had_reg)
                begin
                    result_next.status = ST_MISSING;
                end
                else
                begin
                    result_next.status = ST_OK;
                end
                result_next.length = LengthWidth'(count_next);
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            done_reg    <= 1'b0;
            had_reg     <= 1'b0;
            dropped_reg <= 1'b0;
            empty_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            done_reg    <= done_next;
            had_reg     <= had_next;
            dropped_reg <= dropped_next;
            empty_reg   <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic [7:0] prev_d;
            logic [7:0] next_d;

            if (gi == 0)
            begin : g_front
                assign prev_d = value_reg;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
            end

            if (gi == LIST_DEPTH - 1)
            begin : g_back
                assign next_d = cell_data[0];
            end
            else
            begin : g_inner
                assign next_d = cell_data[gi+1];
            end

            ocl_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .head_data (cell_data[0]),
                .tail_sel  (tail_idx == IW'(gi)),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted operation did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_length: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.length == LengthWidth'(count_reg)))
        else $error("reported length differs from entry count");

endmodule
